[rtl/core/chop_pkg.sv]
`default_nettype none
package chop_pkg;

  localparam int CH_W       = 7;
  localparam int CNT_W      = 5;
  localparam int LVL_W      = 6;
  localparam int TS_W       = 32;
  localparam int HOLD_W     = 16;

  localparam int LEVEL_FULL = 50;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd3000;

  localparam int CHANNELS_DEF = 126;
  localparam int SAMPLES_DEF  = 20;

  // One peak store entry: held level and the time it was set
  typedef struct packed {
    logic [LVL_W-1:0] peak;
    logic [TS_W-1:0]  stamp;
  } peak_ent_t;

  localparam int ENT_W = LVL_W + TS_W;

endpackage
`default_nettype wire

[rtl/core/chop_ram.sv]
`default_nettype none
module chop_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/core/channel_occupancy_peak_hold.sv]
`default_nettype none
// Channel occupancy meter with per-channel peak hold and decay.
//
// Input channel (in_valid/in_ready): one carrier sample per request, with its
// channel, hit flag and millisecond time stamp. Consecutive samples of one
// channel are counted; a sample for another channel drops the partial run.
// Samples with a channel >= CHANNELS are taken and ignored.
// Result channel (out_valid/out_ready): one request on the last sample of a
// run, carrying the channel, the scaled level 0..50 and the updated peak.
// Config channel (cfg_valid/cfg_ready): writes hold_ms; always ready. Write
// only while no run result is in flight.
//
// Throughput: one sample per cycle while the receiver keeps up, also when runs
// complete back to back on the same channel (peak store write is forwarded to the next read).
// Path: a finished run waits in the stage-1 register (peak store read at the
// accepting edge), then its update goes straight into the output register.
// A stalled receiver holds the output register; input keeps flowing until
// a second finished run is waiting behind it, then in_ready drops.
// Reset (synchronous, rst_n low) clears counters, hold_ms to 3000 and marks
// all peak entries as zero through their valid flags; no clearing pass.
module channel_occupancy_peak_hold #(
  parameter int CHANNELS            = chop_pkg::CHANNELS_DEF,
  parameter int SAMPLES_PER_CHANNEL = chop_pkg::SAMPLES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [chop_pkg::CH_W-1:0]    in_channel,
  input  wire logic                         in_carrier_hit,
  input  wire logic [chop_pkg::TS_W-1:0]    in_now_ms,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [chop_pkg::CH_W-1:0]    out_channel_out,
  output logic      [chop_pkg::LVL_W-1:0]   out_level,
  output logic      [chop_pkg::LVL_W-1:0]   out_peak_out,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [chop_pkg::HOLD_W-1:0]  cfg_data
);

  localparam int AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TAB_N   = 2 ** chop_pkg::CNT_W;
  localparam logic [chop_pkg::CNT_W-1:0] RUN_LEN = chop_pkg::CNT_W'(SAMPLES_PER_CHANNEL);
  localparam logic [chop_pkg::CH_W:0]    CH_LIM  = (chop_pkg::CH_W + 1)'(CHANNELS);

  // hits -> level table, worked out at elaboration
  logic [chop_pkg::LVL_W-1:0] lvl_tab [TAB_N];
  for (genvar gi = 0; gi < TAB_N; gi++) begin : g_lvl
    localparam int RAW = (gi * chop_pkg::LEVEL_FULL) / SAMPLES_PER_CHANNEL;
    assign lvl_tab[gi] = chop_pkg::LVL_W'((RAW > chop_pkg::LEVEL_FULL) ?
                                          chop_pkg::LEVEL_FULL : RAW);
  end

  // ---------------- config ----------------
  logic [chop_pkg::HOLD_W-1:0] hold_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= chop_pkg::HOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      hold_r <= cfg_data;
    end
  end

  // ---------------- stage 0: run counting ----------------
  logic [chop_pkg::CNT_W-1:0] cnt_r, cnt_nxt, hits_r, hits_nxt;
  logic [chop_pkg::CH_W-1:0]  cur_ch_r, cur_ch_nxt;
  logic [chop_pkg::CNT_W-1:0] base_cnt, base_hits, cnt_inc, hits_inc;
  logic                       in_fire, in_range, run_done, s1_load;
  logic [AW-1:0]              in_addr;

  logic                       s1_vld_r, s1_go;
  logic [chop_pkg::CH_W-1:0]  s1_ch_r;
  logic [chop_pkg::LVL_W-1:0] s1_lvl_r;
  logic [chop_pkg::TS_W-1:0]  s1_now_r;
  logic                       s1_ent_vld_r, s1_fwd_r;
  chop_pkg::peak_ent_t        s1_fwd_ent_r;

  logic [CHANNELS-1:0]        ent_vld_r;
  chop_pkg::peak_ent_t        rd_ent, old_ent, new_ent;
  logic [chop_pkg::ENT_W-1:0] rd_data;
  logic [AW-1:0]              s1_addr;
  logic                       out_valid_r;

  assign in_fire  = in_valid && in_ready;
  assign in_range = {1'b0, in_channel} < CH_LIM;
  assign in_addr  = in_channel[AW-1:0];
  assign s1_addr  = s1_ch_r[AW-1:0];

  always_comb begin
    if ((cnt_r != '0) && (in_channel != cur_ch_r)) begin
      base_cnt  = '0;
      base_hits = '0;
    end else begin
      base_cnt  = cnt_r;
      base_hits = hits_r;
    end
    cnt_inc  = base_cnt + chop_pkg::CNT_W'(1);
    hits_inc = base_hits + chop_pkg::CNT_W'(in_carrier_hit);
    run_done = (cnt_inc == RUN_LEN);

    cnt_nxt    = cnt_r;
    hits_nxt   = hits_r;
    cur_ch_nxt = cur_ch_r;
    if (in_fire && in_range) begin
      cur_ch_nxt = in_channel;
      cnt_nxt    = run_done ? '0 : cnt_inc;
      hits_nxt   = run_done ? '0 : hits_inc;
    end
  end

  assign s1_load = in_fire && in_range && run_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      hits_r   <= '0;
      cur_ch_r <= '0;
    end else begin
      cnt_r    <= cnt_nxt;
      hits_r   <= hits_nxt;
      cur_ch_r <= cur_ch_nxt;
    end
  end

  // ---------------- stage 1: peak read-modify-write ----------------
  assign s1_go    = s1_vld_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_vld_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s1_fwd_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_load || (s1_vld_r && !s1_go);
      if (s1_load) begin
        // same entry written this cycle: take the write data, not the RAM
        s1_fwd_r <= s1_go && (s1_addr == in_addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_ch_r      <= in_channel;
      s1_lvl_r     <= lvl_tab[hits_inc];
      s1_now_r     <= in_now_ms;
      s1_ent_vld_r <= ent_vld_r[in_addr];
      s1_fwd_ent_r <= new_ent;
    end
  end

  chop_ram #(
    .WIDTH (chop_pkg::ENT_W),
    .DEPTH (CHANNELS)
  ) u_peak_ram (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_addr),
    .wdata (new_ent),
    .re    (s1_load),
    .raddr (in_addr),
    .rdata (rd_data)
  );

  assign rd_ent = rd_data;

  always_comb begin
    if (s1_fwd_r) begin
      old_ent = s1_fwd_ent_r;
    end else if (s1_ent_vld_r) begin
      old_ent = rd_ent;
    end else begin
      old_ent = '0;
    end

    new_ent = old_ent;
    if (s1_lvl_r >= old_ent.peak) begin
      new_ent.peak  = s1_lvl_r;
      new_ent.stamp = s1_now_r;
    end else if (((s1_now_r - old_ent.stamp) > {16'd0, hold_r}) &&
                 (old_ent.peak != '0)) begin
      new_ent.peak = old_ent.peak - chop_pkg::LVL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
    end else if (s1_go) begin
      ent_vld_r[s1_addr] <= 1'b1;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_go || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_channel_out <= s1_ch_r;
      out_level       <= s1_lvl_r;
      out_peak_out    <= new_ent.peak;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !s1_go) |-> !in_ready)
    else $error("input taken while update stage is stalled");

  a_fwd_source: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && s1_fwd_r && $past(s1_load)) |-> $past(s1_go))
    else $error("forward flag set without a matching store write");

  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r < RUN_LEN) && (hits_r <= cnt_r))
    else $error("run counters out of range");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_level <= chop_pkg::LVL_W'(chop_pkg::LEVEL_FULL)) &&
                     (out_peak_out <= chop_pkg::LVL_W'(chop_pkg::LEVEL_FULL))))
    else $error("level or peak above full scale");
`endif

endmodule
`default_nettype wire
